### rtl/core/mcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus coil bank package
// Shared constants, status codes and the command and status structures that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package mcb_pkg;

    localparam int NUM_COILS   = 128;
    localparam int MAX_RESULTS = 16;

    localparam int ADDR_W  = 16;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 8;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 16;

    localparam int POS_W = $clog2(NUM_COILS + 1);
    localparam int EXT_W = $clog2(NUM_COILS + BYTE_W);
    localparam int K_W   = $clog2(MAX_RESULTS);
    localparam int NB_W  = K_W + 1;
    localparam int RNG_W = ADDR_W + 2 + $clog2(NUM_COILS + 1);

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_REG    = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic REG_BANK_BASE = 1'b0;

    typedef struct packed {
        logic load;
        logic do_write;
        logic emit_single;
        logic emit_byte;
    } mcb_cmd_t;

    typedef struct packed {
        logic single;
        logic last_byte;
    } mcb_stat_t;

endpackage

`default_nettype wire

### rtl/core/modbus_coil_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus coil bank
// Bit-addressed coil store of a Modbus slave with a command-style request
// channel, a strobed result channel and an APB-style configuration port.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge where start is high and busy is
// low. The one-based address is made zero-based and checked against the
// bank base register and the bank size; a failed check gives one result with
// status no_register. A read gives one packed byte per cycle, the last one
// marked by last; a write stores one data byte and gives one result.
// Each result is shown for exactly one cycle while result_valid is high; the
// receiver cannot stall the block, so no result is ever held back.
// The request is registered at acceptance and the first result is registered
// from the evaluation state that follows. Busy stays high while the controller
// evaluates or emits read bytes, so no new transaction is accepted before the
// last one is done; the controller emits one byte per cycle from the store.
// The bank base register is written through the APB port where paddr[2] is 0.
// The user must write it only while the block is idle; this is not enforced.
// Reset clears the whole coil store, the bank base register and the
// controller at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module modbus_coil_bank (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         kind,
    input  wire logic [mcb_pkg::ADDR_W-1:0]   address,
    input  wire logic [mcb_pkg::COUNT_W-1:0]  count,
    input  wire logic [mcb_pkg::INDEX_W-1:0]  byte_index,
    input  wire logic [mcb_pkg::BYTE_W-1:0]   data_byte,
    output logic                              result_valid,
    output logic [mcb_pkg::BYTE_W-1:0]        read_byte,
    output logic [1:0]                        status,
    output logic                              last
);

    logic [mcb_pkg::CFG_W-1:0] bank_base_reg;
    logic                      ctrl_busy;
    mcb_pkg::mcb_cmd_t         cmd;
    mcb_pkg::mcb_stat_t        stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_base_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == mcb_pkg::REG_BANK_BASE))
        begin
            bank_base_reg <= pwdata[mcb_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == mcb_pkg::REG_BANK_BASE)
        begin
            prdata = 32'(bank_base_reg);
        end
    end

    assign pready = 1'b1;

    mcb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (ctrl_busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    mcb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .bank_base    (bank_base_reg),
        .kind         (kind),
        .address      (address),
        .count        (count),
        .byte_index   (byte_index),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .read_byte    (read_byte),
        .status       (status),
        .last         (last)
    );

    assign busy = ctrl_busy;

endmodule

`default_nettype wire

### rtl/core/mcb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus coil bank datapath
// Holds the request, the bit-packed coil store and the result registers, and
// performs the range checks, the byte extraction and the masked bit writes.
// ----------------------------------------------------------------------------
module mcb_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mcb_pkg::mcb_cmd_t                cmd,
    output mcb_pkg::mcb_stat_t                    stat,
    input  wire logic [mcb_pkg::CFG_W-1:0]        bank_base,
    input  wire logic                             kind,
    input  wire logic [mcb_pkg::ADDR_W-1:0]       address,
    input  wire logic [mcb_pkg::COUNT_W-1:0]      count,
    input  wire logic [mcb_pkg::INDEX_W-1:0]      byte_index,
    input  wire logic [mcb_pkg::BYTE_W-1:0]       data_byte,
    output logic                                  result_valid,
    output logic [mcb_pkg::BYTE_W-1:0]            read_byte,
    output logic [1:0]                            status,
    output logic                                  last
);

    logic                               kind_reg;
    logic [mcb_pkg::ADDR_W-1:0]         addr_reg;
    logic [mcb_pkg::COUNT_W-1:0]        count_reg;
    logic [mcb_pkg::INDEX_W-1:0]        bidx_reg;
    logic [mcb_pkg::BYTE_W-1:0]         data_reg;
    logic [mcb_pkg::K_W-1:0]            k_reg;
    logic [mcb_pkg::K_W-1:0]            k_next;
    logic [mcb_pkg::NUM_COILS-1:0]      coil_reg;
    logic [mcb_pkg::NUM_COILS-1:0]      coil_next;
    logic                               strobe_reg;
    logic [mcb_pkg::BYTE_W-1:0]         byte_reg;
    logic [1:0]                         status_reg;
    logic                               last_reg;

    logic [mcb_pkg::RNG_W-1:0]          addr_ext;
    logic [mcb_pkg::RNG_W-1:0]          start_ext;
    logic                               range_err;
    logic [mcb_pkg::ADDR_W-1:0]         base_full;
    logic [mcb_pkg::POS_W-1:0]          base;
    logic [mcb_pkg::COUNT_W-1:0]        first;
    logic                               index_err;
    logic [mcb_pkg::COUNT_W-1:0]        remain;
    logic [3:0]                         wcount;
    logic [mcb_pkg::POS_W-1:0]          wpos;
    logic [mcb_pkg::POS_W:0]            woff;
    logic                               write_en;
    logic [mcb_pkg::COUNT_W-1:0]        cnt_round;
    logic [mcb_pkg::COUNT_W-4:0]        nbytes;
    logic [mcb_pkg::NB_W-1:0]           nb;
    logic [mcb_pkg::EXT_W-1:0]          rpos;
    logic [mcb_pkg::NUM_COILS+mcb_pkg::BYTE_W-1:0] coil_ext;
    logic [mcb_pkg::BYTE_W-1:0]         raw_byte;
    logic [mcb_pkg::BYTE_W-1:0]         masked_byte;
    logic [mcb_pkg::COUNT_W-1:0]        cidx;
    logic [1:0]                         single_status;

    always_comb
    begin
        addr_ext  = mcb_pkg::RNG_W'(addr_reg);
        start_ext = mcb_pkg::RNG_W'(bank_base);
        range_err = (addr_reg < bank_base) ||
                    (addr_ext + mcb_pkg::RNG_W'(count_reg) >
                     start_ext + mcb_pkg::RNG_W'(mcb_pkg::NUM_COILS));
        base_full = addr_reg - bank_base;
        base      = base_full[mcb_pkg::POS_W-1:0];

        first     = {bidx_reg, 3'b000};
        index_err = (first >= count_reg);
        remain    = count_reg - first;
        wcount    = (remain > mcb_pkg::COUNT_W'(8)) ? 4'd8 : remain[3:0];
        wpos      = base + mcb_pkg::POS_W'(first);
        write_en  = cmd.do_write && !range_err && (kind_reg == mcb_pkg::KIND_WRITE) &&
                    !index_err;

        coil_next = coil_reg;
        for (int j = 0; j < mcb_pkg::NUM_COILS; j++)
        begin
            woff = (mcb_pkg::POS_W+1)'(j) - {1'b0, wpos};
            if (write_en && (woff < (mcb_pkg::POS_W+1)'(wcount)))
            begin
                coil_next[j] = data_reg[woff[2:0]];
            end
        end

        cnt_round = count_reg + mcb_pkg::COUNT_W'(7);
        nbytes    = cnt_round[mcb_pkg::COUNT_W-1:3];
        nb        = (nbytes > (mcb_pkg::COUNT_W-3)'(mcb_pkg::MAX_RESULTS)) ?
                    mcb_pkg::NB_W'(mcb_pkg::MAX_RESULTS) : mcb_pkg::NB_W'(nbytes);

        coil_ext = {{mcb_pkg::BYTE_W{1'b0}}, coil_reg};
        rpos     = mcb_pkg::EXT_W'(base) + mcb_pkg::EXT_W'({k_reg, 3'b000});
        raw_byte = coil_ext[rpos +: mcb_pkg::BYTE_W];
        for (int i = 0; i < mcb_pkg::BYTE_W; i++)
        begin
            cidx = mcb_pkg::COUNT_W'({k_reg, 3'b000}) + mcb_pkg::COUNT_W'(i);
            masked_byte[i] = (cidx < count_reg) ? raw_byte[i] : 1'b0;
        end

        if (range_err)
        begin
            single_status = mcb_pkg::STATUS_NO_REG;
        end
        else if ((kind_reg == mcb_pkg::KIND_WRITE) && index_err)
        begin
            single_status = mcb_pkg::STATUS_BAD_INDEX;
        end
        else
        begin
            single_status = mcb_pkg::STATUS_OK;
        end

        stat.single    = range_err || (kind_reg == mcb_pkg::KIND_WRITE) ||
                         (count_reg == '0);
        stat.last_byte = (mcb_pkg::NB_W'(k_reg) + mcb_pkg::NB_W'(1)) == nb;

        k_next = k_reg;
        if (cmd.load)
        begin
            k_next = '0;
        end
        else if (cmd.emit_byte)
        begin
            k_next = k_reg + mcb_pkg::K_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            addr_reg  <= address - mcb_pkg::ADDR_W'(1);
            count_reg <= count;
            bidx_reg  <= byte_index;
            data_reg  <= data_byte;
        end
        k_reg <= k_next;
        if (cmd.emit_single)
        begin
            byte_reg   <= '0;
            status_reg <= single_status;
            last_reg   <= 1'b1;
        end
        else if (cmd.emit_byte)
        begin
            byte_reg   <= masked_byte;
            status_reg <= mcb_pkg::STATUS_OK;
            last_reg   <= stat.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            coil_reg   <= coil_next;
            strobe_reg <= cmd.emit_single || cmd.emit_byte;
        end
    end

    assign result_valid = strobe_reg;
    assign read_byte    = byte_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### rtl/core/mcb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus coil bank controller
// Sequences one transaction at a time: load, evaluation with the write or the
// first result, then one packed byte per cycle for reads.
// ----------------------------------------------------------------------------
module mcb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mcb_pkg::mcb_stat_t stat,
    output mcb_pkg::mcb_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.do_write = 1'b1;
                if (stat.single)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.emit_byte = 1'b1;
                    state_next    = stat.last_byte ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.emit_byte = 1'b1;
                if (stat.last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire
